// ----- sv/wncd_pkg.sv -----
// Package for weighted_nested_chain_dp: sizes, cell data types, state encoding, saturating add.
// No dependencies; imported by wncd_cell, weighted_nested_chain_dp and both verif files.
`default_nettype none
package wncd_pkg;

   localparam int MAX_RECTS = 32;
   localparam int IDX_W     = $clog2(MAX_RECTS);
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);
   localparam int SUM_W     = 40;
   localparam int SIDE_W    = 32;
   localparam int WGT_W     = 32;

   typedef struct packed {
      logic [SIDE_W-1:0]       len;
      logic [SIDE_W-1:0]       wid;
      logic signed [WGT_W-1:0] weight;
      logic [IDX_W-1:0]        idx;
      logic                    flip;
      logic                    elig;
   } rect_type;

   typedef struct packed {
      logic     valid;
      rect_type rect;
   } sort_type;

   typedef struct packed {
      logic                    valid;
      logic [IDX_W-1:0]        pos;
      logic [SIDE_W-1:0]       len;
      logic [SIDE_W-1:0]       wid;
      logic                    elig;
      logic signed [SUM_W-1:0] best;
      logic                    run_have;
      logic signed [SUM_W-1:0] run_best;
      logic [IDX_W-1:0]        run_end;
   } token_type;

   typedef struct packed {
      logic clear;
      logic init;
      logic start;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_INIT,
      ST_START,
      ST_DP,
      ST_TRACE,
      ST_EMIT
   } state_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [WGT_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      logic signed [SUM_W-1:0] r;
      s = {a[SUM_W-1], a} + {{(SUM_W + 1 - WGT_W){b[WGT_W-1]}}, b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = s[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/wncd_cell.sv -----
// One cell of the rectangle chain: sorting slot, DP entry and token stage.
// Depends on wncd_pkg.
`default_nettype none
module wncd_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wncd_pkg::cell_cmd_type    cmd,
   input  wire logic [wncd_pkg::IDX_W-1:0] my_pos,
   input  wire wncd_pkg::sort_type        sort_in,
   output wncd_pkg::sort_type             sort_out,
   input  wire wncd_pkg::token_type       tok_in,
   output wncd_pkg::token_type            tok_out,
   output logic [wncd_pkg::CNT_W-1:0]     pred,
   output logic [wncd_pkg::IDX_W-1:0]     orig_idx,
   output logic                           flipped
);
   import wncd_pkg::*;

   logic                    occ_ff, occ_in;
   rect_type                item_ff, item_in;
   logic signed [SUM_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]        pred_ff, pred_in;
   logic                    run_have_ff, run_have_in;
   logic signed [SUM_W-1:0] run_best_ff, run_best_in;
   logic [IDX_W-1:0]        run_end_ff, run_end_in;
   logic                    go_ff, go_in;
   sort_type                sort_out_ff, sort_out_in;
   token_type               tok_out_ff, tok_out_in;
   logic                    elig;
   logic                    hit;
   logic signed [SUM_W-1:0] cand;

   always_comb begin
      occ_in      = occ_ff;
      item_in     = item_ff;
      best_in     = best_ff;
      pred_in     = pred_ff;
      run_have_in = run_have_ff;
      run_best_in = run_best_ff;
      run_end_in  = run_end_ff;
      sort_out_in = '0;
      elig        = occ_ff & item_ff.elig;
      cand        = sat_add(tok_in.best, item_ff.weight);
      hit         = tok_in.valid &&
                    (({1'b0, tok_in.pos} + CNT_W'(1)) == {1'b0, my_pos});
      go_in       = hit | cmd.start;

      // insertion sort: keep the smaller key, pass the other on
      if (sort_in.valid) begin
         if (!occ_ff) begin
            occ_in  = 1'b1;
            item_in = sort_in.rect;
         end else if ({sort_in.rect.len, sort_in.rect.idx} < {item_ff.len, item_ff.idx}) begin
            item_in          = sort_in.rect;
            sort_out_in.valid = 1'b1;
            sort_out_in.rect  = item_ff;
         end else begin
            sort_out_in = sort_in;
         end
      end

      if (tok_in.valid && elig && tok_in.elig && (tok_in.len < item_ff.len) &&
          (tok_in.wid < item_ff.wid) && (cand > best_ff)) begin
         best_in = cand;
         pred_in = {1'b0, tok_in.pos} + CNT_W'(1);
      end
      if (hit) begin
         run_have_in = tok_in.run_have;
         run_best_in = tok_in.run_best;
         run_end_in  = tok_in.run_end;
      end

      if (go_ff) begin
         tok_out_in.valid    = 1'b1;
         tok_out_in.pos      = my_pos;
         tok_out_in.len      = item_ff.len;
         tok_out_in.wid      = item_ff.wid;
         tok_out_in.elig     = elig;
         tok_out_in.best     = best_ff;
         if (elig && (!run_have_ff || (run_best_ff < best_ff))) begin
            tok_out_in.run_have = 1'b1;
            tok_out_in.run_best = best_ff;
            tok_out_in.run_end  = my_pos;
         end else begin
            tok_out_in.run_have = run_have_ff;
            tok_out_in.run_best = run_best_ff;
            tok_out_in.run_end  = run_end_ff;
         end
      end else begin
         tok_out_in = tok_in;
      end

      if (cmd.init) begin
         best_in     = elig ? {{(SUM_W-WGT_W){item_ff.weight[WGT_W-1]}}, item_ff.weight}
                            : '0;
         pred_in     = '0;
         run_have_in = 1'b0;
         go_in       = 1'b0;
         tok_out_in  = '0;
      end
      if (cmd.clear) begin
         occ_in      = 1'b0;
         sort_out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= 1'b0;
         go_ff       <= 1'b0;
         run_have_ff <= 1'b0;
         sort_out_ff <= '0;
         tok_out_ff  <= '0;
      end else begin
         occ_ff      <= occ_in;
         go_ff       <= go_in;
         run_have_ff <= run_have_in;
         sort_out_ff <= sort_out_in;
         tok_out_ff  <= tok_out_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      best_ff     <= best_in;
      pred_ff     <= pred_in;
      run_best_ff <= run_best_in;
      run_end_ff  <= run_end_in;
   end

   assign sort_out = sort_out_ff;
   assign tok_out  = tok_out_ff;
   assign pred     = pred_ff;
   assign orig_idx = item_ff.idx;
   assign flipped  = item_ff.flip;

endmodule
`default_nettype wire

// ----- sv/weighted_nested_chain_dp.sv -----
// Top level of the weighted nested-rectangle chain finder.
// Depends on wncd_pkg and wncd_cell.
// Requests load one rectangle per cycle while the block is in its load state,
// into a row of MAX_RECTS cells that sort them on the fly. After the request
// marked last, the row drains, then a token wave runs down the row to settle
// the best chain; the trace-back walks the chain members one by one and
// emission sends one result per member, or a single result for an empty
// chain. Configuration is sampled as each rectangle is loaded.
`default_nettype none
module weighted_nested_chain_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [wncd_pkg::SIDE_W-1:0]   req_item_length,
   input  wire logic [wncd_pkg::SIDE_W-1:0]   req_item_width,
   input  wire logic signed [wncd_pkg::WGT_W-1:0] req_item_weight,
   input  wire logic                          req_last_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [wncd_pkg::SUM_W-1:0]  rsp_total_weight,
   output logic [wncd_pkg::CNT_W-1:0]         rsp_chain_count,
   output logic [wncd_pkg::CNT_W-1:0]         rsp_member_index,
   output logic                               rsp_member_rotated,
   output logic                               rsp_end_of_run,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [wncd_pkg::SIDE_W-1:0]   csr_data
);
   import wncd_pkg::*;

   localparam logic CSR_CARD_LENGTH = 1'b0;
   localparam logic CSR_CARD_WIDTH  = 1'b1;

   state_type               state_ff, state_in;
   logic [SIDE_W-1:0]       card_len_ff, card_wid_ff;
   logic [CNT_W-1:0]        loaded_ff, loaded_in;
   logic [CNT_W-1:0]        drain_ff, drain_in;
   logic [CNT_W-1:0]        sp_ff, sp_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]        trace_ff, trace_in;
   logic                    have_ff, have_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0]        stack_ff [MAX_RECTS];
   logic                    stack_we;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                    rsp_rot_ff, rsp_rot_in;
   logic                    rsp_end_ff, rsp_end_in;

   cell_cmd_type            cmd;
   sort_type                sort_head;
   sort_type                sort_link [MAX_RECTS+1];
   token_type               tok_link  [MAX_RECTS+1];
   logic [CNT_W-1:0]        cell_pred [MAX_RECTS];
   logic [IDX_W-1:0]        cell_idx  [MAX_RECTS];
   logic                    cell_flip [MAX_RECTS];

   logic                    rot;
   logic [SIDE_W-1:0]       o_len, o_wid;
   logic [CNT_W-1:0]        pred_sel;
   logic [IDX_W-1:0]        emit_pos;
   token_type               tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         card_len_ff <= '0;
         card_wid_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CARD_LENGTH: card_len_ff <= csr_data;
            CSR_CARD_WIDTH:  card_wid_ff <= csr_data;
            default:         card_len_ff <= card_len_ff;
         endcase
      end
   end

   always_comb begin
      rot = ((card_len_ff < card_wid_ff) && (req_item_length > req_item_width)) ||
            ((card_len_ff > card_wid_ff) && (req_item_length < req_item_width));
      o_len = rot ? req_item_width  : req_item_length;
      o_wid = rot ? req_item_length : req_item_width;
      sort_head.valid       = 1'b0;
      sort_head.rect.len    = o_len;
      sort_head.rect.wid    = o_wid;
      sort_head.rect.weight = req_item_weight;
      sort_head.rect.idx    = loaded_ff[IDX_W-1:0];
      sort_head.rect.flip   = rot;
      sort_head.rect.elig   = (card_len_ff < o_len) && (card_wid_ff < o_wid);
      if ((state_ff == ST_LOAD) && req_valid && (loaded_ff < CNT_W'(MAX_RECTS))) begin
         sort_head.valid = 1'b1;
      end
   end

   assign sort_link[0] = sort_head;
   assign tok_link[0]  = '0;
   assign tail         = tok_link[MAX_RECTS];

   for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
      cell_cmd_type cell_cmd;
      always_comb begin
         cell_cmd       = cmd;
         cell_cmd.start = (k == 0) ? cmd.start : 1'b0;
      end
      wncd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cell_cmd),
         .my_pos   (IDX_W'(k)),
         .sort_in  (sort_link[k]),
         .sort_out (sort_link[k+1]),
         .tok_in   (tok_link[k]),
         .tok_out  (tok_link[k+1]),
         .pred     (cell_pred[k]),
         .orig_idx (cell_idx[k]),
         .flipped  (cell_flip[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      drain_in     = drain_ff;
      sp_in        = sp_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      trace_in     = trace_ff;
      have_in      = have_ff;
      total_in     = total_ff;
      stack_we     = 1'b0;
      cmd          = '0;
      req_ready    = (state_ff == ST_LOAD);
      pred_sel     = cell_pred[trace_ff];
      emit_pos     = stack_ff[k_ff[IDX_W-1:0] - IDX_W'(1)];
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_index_in = rsp_index_ff;
      rsp_rot_in   = rsp_rot_ff;
      rsp_end_in   = rsp_end_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (loaded_ff < CNT_W'(MAX_RECTS)) begin
                  loaded_in = loaded_ff + CNT_W'(1);
               end
               if (req_last_item) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + CNT_W'(1);
            if (drain_ff == CNT_W'(MAX_RECTS - 1)) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_DP;
         end
         ST_DP: begin
            if (tail.valid && (tail.pos == IDX_W'(MAX_RECTS - 1))) begin
               have_in  = tail.run_have;
               total_in = tail.run_have ? tail.run_best : '0;
               trace_in = tail.run_end;
               sp_in    = '0;
               count_in = '0;
               k_in     = '0;
               state_in = tail.run_have ? ST_TRACE : ST_EMIT;
            end
         end
         ST_TRACE: begin
            stack_we = 1'b1;
            sp_in    = sp_ff + CNT_W'(1);
            trace_in = pred_sel[IDX_W-1:0] - IDX_W'(1);
            if ((pred_sel == '0) || (sp_in == CNT_W'(MAX_RECTS))) begin
               count_in = sp_in;
               k_in     = sp_in;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               rsp_count_in = count_ff;
               if (count_ff == '0) begin
                  rsp_index_in = '0;
                  rsp_rot_in   = 1'b0;
                  rsp_end_in   = 1'b1;
               end else begin
                  rsp_index_in = {1'b0, cell_idx[emit_pos]} + CNT_W'(1);
                  rsp_rot_in   = cell_flip[emit_pos];
                  rsp_end_in   = (k_ff == CNT_W'(1));
                  k_in         = k_ff - CNT_W'(1);
               end
               if (rsp_end_in) begin
                  cmd.clear = 1'b1;
                  loaded_in = '0;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drain_ff     <= drain_in;
      sp_ff        <= sp_in;
      count_ff     <= count_in;
      k_ff         <= k_in;
      trace_ff     <= trace_in;
      have_ff      <= have_in;
      total_ff     <= total_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_index_ff <= rsp_index_in;
      rsp_rot_ff   <= rsp_rot_in;
      rsp_end_ff   <= rsp_end_in;
      if (stack_we) begin
         stack_ff[sp_ff[IDX_W-1:0]] <= trace_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_weight   = rsp_total_ff;
   assign rsp_chain_count    = rsp_count_ff;
   assign rsp_member_index   = rsp_index_ff;
   assign rsp_member_rotated = rsp_rot_ff;
   assign rsp_end_of_run     = rsp_end_ff;

endmodule
`default_nettype wire

// ----- verif/wncd_chain_checker.sv -----
// Checker for weighted_nested_chain_dp: watches the request, response and register
// ports, keeps its own copy of the rectangle store and predicts each chain.
// Depends on wncd_pkg; instantiated by tb_weighted_nested_chain_dp.
module wncd_chain_checker
   import wncd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [SIDE_W-1:0]       req_item_length,
   input  logic [SIDE_W-1:0]       req_item_width,
   input  logic signed [WGT_W-1:0] req_item_weight,
   input  logic                    req_last_item,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [SUM_W-1:0] rsp_total_weight,
   input  logic [CNT_W-1:0]        rsp_chain_count,
   input  logic [CNT_W-1:0]        rsp_member_index,
   input  logic                    rsp_member_rotated,
   input  logic                    rsp_end_of_run,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [SIDE_W-1:0]       csr_data,
   output int                      fail_count,
   output int                      pending
);

   localparam longint SUM_HI = 64'sd549755813887;
   localparam longint SUM_LO = -64'sd549755813888;

   typedef struct packed {
      logic signed [SUM_W-1:0] total;
      logic [CNT_W-1:0]        count;
      logic [CNT_W-1:0]        index;
      logic                    rotated;
      logic                    last;
   } member_type;

   member_type chain_q[$];

   logic [SIDE_W-1:0] card_len, card_wid;
   logic [SIDE_W-1:0] rect_len[MAX_RECTS];
   logic [SIDE_W-1:0] rect_wid[MAX_RECTS];
   longint            rect_wgt[MAX_RECTS];
   logic              rect_rot[MAX_RECTS];
   int                n_loaded;

   task automatic report(input string what, input longint got, input longint want);
      $display("wncd_chain_checker: %0t mismatch on %s: got %0d, expected %0d",
               $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic longint clamp_add(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > SUM_HI) return SUM_HI;
      if (s < SUM_LO) return SUM_LO;
      return s;
   endfunction

   task automatic predict_chain();
      int     order[MAX_RECTS];
      longint best[MAX_RECTS];
      int     link[MAX_RECTS];
      logic   ok[MAX_RECTS];
      int     chain[MAX_RECTS];
      int     i, j, v, t, cnt, best_end;
      longint total, cand;
      logic   have;
      member_type m;
      have = 0;
      total = 0;
      best_end = 0;
      cnt = 0;
      for (i = 0; i < n_loaded; i++) begin
         v = i;
         j = i;
         while (j > 0 && rect_len[order[j-1]] > rect_len[v]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
      end
      for (i = 0; i < n_loaded; i++) begin
         link[i] = 0;
         ok[i] = card_len < rect_len[order[i]] && card_wid < rect_wid[order[i]];
         best[i] = 0;
         if (ok[i]) begin
            best[i] = rect_wgt[order[i]];
            for (j = 0; j < i; j++) begin
               if (ok[j] && rect_wid[order[i]] > rect_wid[order[j]] &&
                   rect_len[order[i]] > rect_len[order[j]]) begin
                  cand = clamp_add(best[j], rect_wgt[order[i]]);
                  if (cand > best[i]) begin
                     best[i] = cand;
                     link[i] = j + 1;
                  end
               end
            end
            if (!have || total < best[i]) begin
               total = best[i];
               best_end = i;
               have = 1;
            end
         end
      end
      n_loaded = 0;
      if (!have) begin
         m = '{total: '0, count: '0, index: '0, rotated: 1'b0, last: 1'b1};
         chain_q.insert(chain_q.size(), m);
      end else begin
         t = best_end + 1;
         while (t != 0 && cnt < MAX_RECTS) begin
            chain[cnt] = t - 1;
            cnt = cnt + 1;
            t = link[t-1];
         end
         for (i = 0; i < cnt; i++) begin
            v = order[chain[cnt-1-i]];
            m.total   = total[SUM_W-1:0];
            m.count   = cnt[CNT_W-1:0];
            m.index   = CNT_W'(v + 1);
            m.rotated = rect_rot[v];
            m.last    = (i + 1 == cnt);
            chain_q.insert(chain_q.size(), m);
         end
      end
   endtask

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      logic [SIDE_W-1:0] l, w;
      logic              r;
      member_type        m;
      if (reset) begin
         card_len = '0;
         card_wid = '0;
         n_loaded = 0;
      end else begin
         if (csr_write) begin
            if (csr_index) card_wid = csr_data;
            else card_len = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (chain_q.size() == 0) begin
               $display("wncd_chain_checker: %0t response with nothing expected", $realtime);
               fail_count++;
            end else begin
               m = chain_q.pop_front();
               if (rsp_total_weight !== m.total)
                  report("total_weight", rsp_total_weight, m.total);
               if (rsp_chain_count !== m.count)
                  report("chain_count", rsp_chain_count, m.count);
               if (rsp_member_index !== m.index)
                  report("member_index", rsp_member_index, m.index);
               if (rsp_member_rotated !== m.rotated)
                  report("member_rotated", rsp_member_rotated, m.rotated);
               if (rsp_end_of_run !== m.last)
                  report("end_of_run", rsp_end_of_run, m.last);
            end
         end
         if (req_valid && req_ready) begin
            if (n_loaded < MAX_RECTS) begin
               l = req_item_length;
               w = req_item_width;
               r = (card_len < card_wid && l > w) || (card_len > card_wid && l < w);
               rect_len[n_loaded] = r ? w : l;
               rect_wid[n_loaded] = r ? l : w;
               rect_wgt[n_loaded] = longint'(req_item_weight);
               rect_rot[n_loaded] = r;
               n_loaded++;
            end
            if (req_last_item) predict_chain();
         end
      end
      pending = chain_q.size();
   end

endmodule

// ----- verif/tb_weighted_nested_chain_dp.sv -----
// Testbench top for weighted_nested_chain_dp: clock, reset, card settings and
// rectangle requests with random gaps; the verdict comes from wncd_chain_checker.
// Depends on wncd_pkg, weighted_nested_chain_dp and wncd_chain_checker.
module tb_weighted_nested_chain_dp;
   import wncd_pkg::*;

   localparam logic REG_CARD_LENGTH = 1'b0;
   localparam logic REG_CARD_WIDTH  = 1'b1;
   localparam logic [SIDE_W-1:0] SIDE_MAX = '1;

   logic                    clock, reset;
   logic                    req_valid, req_ready;
   logic [SIDE_W-1:0]       req_item_length, req_item_width;
   logic signed [WGT_W-1:0] req_item_weight;
   logic                    req_last_item;
   logic                    rsp_valid, rsp_ready;
   logic signed [SUM_W-1:0] rsp_total_weight;
   logic [CNT_W-1:0]        rsp_chain_count, rsp_member_index;
   logic                    rsp_member_rotated, rsp_end_of_run;
   logic                    csr_write, csr_index;
   logic [SIDE_W-1:0]       csr_data;
   int                      fail_count, pending;
   int                      items_sent;

   weighted_nested_chain_dp dut (.*);

   wncd_chain_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb_weighted_nested_chain_dp: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, one long hold-off while requests keep coming
   initial begin
      int   cycles;
      logic held;
      rsp_ready = 1'b0;
      cycles = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycles++;
         if (!held && items_sent >= 100) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         if (cycles > 8000 && cycles < 9000) rsp_ready <= 1'b1;
         else if (rsp_ready) rsp_ready <= ($urandom_range(0, 9) != 0);
         else rsp_ready <= (pick_gap() == 0);
      end
   end

   task automatic send(input logic [SIDE_W-1:0] l, input logic [SIDE_W-1:0] w,
                       input logic signed [WGT_W-1:0] wt, input logic last);
      int   gap;
      logic ok;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_item_length <= l;
      req_item_width  <= w;
      req_item_weight <= wt;
      req_last_item   <= last;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_card(input logic [SIDE_W-1:0] l, input logic [SIDE_W-1:0] w);
      csr_write <= 1'b1;
      csr_index <= REG_CARD_LENGTH;
      csr_data  <= l;
      @(posedge clock);
      csr_index <= REG_CARD_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SIDE_W-1:0] rand_side();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 40);
   endfunction

   function automatic logic signed [WGT_W-1:0] rand_weight();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom;
      if (r == 1) return {1'b1, {(WGT_W-1){1'b0}}};
      if (r == 2) return {1'b0, {(WGT_W-1){1'b1}}};
      return $signed($urandom_range(0, 200)) - 60;
   endfunction

   task automatic random_run(input int count);
      for (int i = 0; i < count; i++)
         send(rand_side(), rand_side(), rand_weight(), i == count - 1);
   endtask

   initial begin
      int n;
      items_sent      = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_item_length = '0;
      req_item_width  = '0;
      req_item_weight = '0;
      req_last_item   = 1'b0;
      csr_write       = 1'b0;
      csr_index       = REG_CARD_LENGTH;
      csr_data        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty chain, lone negative, ties, zero weight
      send('0, '0, 32'sd5, 1'b1);
      send(SIDE_MAX, SIDE_MAX, {1'b1, {(WGT_W-1){1'b0}}}, 1'b1);
      send(6, 6, -32'sd3, 1'b0);
      send(9, 9, -32'sd7, 1'b1);
      send(5, 5, 32'sd10, 1'b0);
      send(5, 7, 32'sd10, 1'b0);
      send(8, 8, 32'sd10, 1'b0);
      send(8, 9, 32'sd20, 1'b0);
      send(12, 12, 32'sd0, 1'b0);
      send(12, 3, 32'sd30, 1'b1);
      settle();
      set_card(4, 10);
      send(20, 5, 32'sd4, 1'b0);
      send(12, 30, 32'sd6, 1'b0);
      send(50, 60, 32'sd1, 1'b1);
      settle();
      set_card(10, 4);
      send(5, 20, 32'sd4, 1'b0);
      send(30, 12, 32'sd6, 1'b0);
      send(7, 7, 32'sd9, 1'b1);
      settle();
      set_card(SIDE_MAX, SIDE_MAX);
      send(SIDE_MAX, SIDE_MAX, {1'b0, {(WGT_W-1){1'b1}}}, 1'b0);
      send(SIDE_MAX - 1, 3, 32'sd1, 1'b1);
      settle();

      // full store and a 32-deep chain, then overflow requests
      set_card(0, 0);
      for (int i = 0; i < MAX_RECTS + 3; i++)
         send(i + 1, i + 1, {1'b0, {(WGT_W-1){1'b1}}}, i == MAX_RECTS + 2);
      settle();

      // random phases over several card settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_card(0, 0);
            1: set_card(3, 12);
            2: set_card(12, 3);
            3: set_card(SIDE_MAX, 0);
            4: set_card(7, 7);
            default: set_card($urandom_range(0, 15), $urandom_range(0, 15));
         endcase
         while (items_sent < 40 + 20 * (phase + 1)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 36) : $urandom_range(1, 8);
            random_run(n);
         end
         settle();
      end

      if (fail_count == 0 && pending == 0)
         $display("tb_weighted_nested_chain_dp: PASS");
      else
         $display("tb_weighted_nested_chain_dp: FAIL");
      $finish;
   end

endmodule

// ----- weighted_nested_chain_dp.f -----
sv/wncd_pkg.sv
sv/wncd_cell.sv
sv/weighted_nested_chain_dp.sv
verif/wncd_chain_checker.sv
verif/tb_weighted_nested_chain_dp.sv
